// File: rtl/sop1_pkg.sv
// Shared types and constants for the scalar one-source execute unit.
// Used by the ALU, the register banks and the top level; depends on nothing.
`default_nettype none

package sop1_pkg;

    // Number of usable scalar registers; indexes at or above it are flagged.
    localparam int unsigned NUM_SCALAR_REGS = 128;

    // The register file is split into an even and an odd bank of this depth.
    localparam int unsigned BANK_DEPTH = 64;
    localparam int unsigned BANK_AW    = $clog2(BANK_DEPTH);

    localparam logic [31:0] PC_STEP = 32'd4;

    typedef enum logic [3:0] {
        ACT_MOV32   = 4'd0,
        ACT_MOV64   = 4'd1,
        ACT_NOT     = 4'd2,
        ACT_BREV    = 4'd3,
        ACT_BITCLR  = 4'd4,
        ACT_GETPC   = 4'd5,
        ACT_SETPC   = 4'd6,
        ACT_SWAPPC  = 4'd7,
        ACT_ANDSAVE = 4'd8,
        ACT_ORSAVE  = 4'd9,
        ACT_WQM     = 4'd10
    } action_t;

    localparam logic [1:0] ERR_NONE        = 2'd0;
    localparam logic [1:0] ERR_UNSUPPORTED = 2'd1;
    localparam logic [1:0] ERR_RANGE       = 2'd2;
    localparam logic [1:0] ERR_TARGET      = 2'd3;

    // Register file write request for one instruction (low word and pair word).
    typedef struct packed {
        logic        lo_en;
        logic        hi_en;
        logic [6:0]  lo_addr;
        logic [6:0]  hi_addr;
        logic [31:0] lo_data;
        logic [31:0] hi_data;
    } wr_ctrl_t;

    // One result transfer.
    typedef struct packed {
        logic [31:0] written_low;
        logic [31:0] written_high;
        logic        condition_out;
        logic        jump_taken;
        logic [31:0] jump_target;
        logic [1:0]  error_code;
    } result_t;

    // Update of the execute mask.
    typedef struct packed {
        logic        we;
        logic [63:0] value;
    } mask_upd_t;

endpackage

`default_nettype wire

// File: rtl/scalar_sop1_execute_unit.sv
// Scalar one-source execute unit: register banks, instruction stage, ALU, result register.
// An item passes the instruction stage and then the result register before it is offered;
// one item per cycle is taken while result_stall does not hold the result register, with a single
// ALU pass between instruction and result registers.
// Reset clears the register file to zero (through valid bits), sets the execute mask
// to all ones and the condition bit to zero; the unit accepts items right after reset.
`default_nettype none

module scalar_sop1_execute_unit (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        item_valid,
    output logic        item_stall,
    input  logic [3:0]  action,
    input  logic [6:0]  dest_index,
    input  logic [6:0]  source_index,
    input  logic        source_is_literal,
    input  logic [31:0] literal_word,
    input  logic [31:0] current_pc,

    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] written_low,
    output logic [31:0] written_high,
    output logic        condition_out,
    output logic        jump_taken,
    output logic [31:0] jump_target,
    output logic [1:0]  error_code
);
    import sop1_pkg::*;

    // Pipeline overview:
    //   Transfer edge: the instruction fields are captured in the instruction stage and
    //   the register banks are read at the source, source plus one and destination.
    //   Then the ALU works on the captured fields and the bank read data, and at the
    //   edge where the stage advances the result register loads while the register file, the
    //   execute mask and the condition bit are updated. A younger instruction read at
    //   that same edge gets the freshly written words through the forwarding registers.

    // Instruction stage.
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [3:0]  s1_action_reg;
    logic [6:0]  s1_dest_reg;
    logic [6:0]  s1_source_reg;
    logic        s1_literal_sel_reg;
    logic [31:0] s1_literal_reg;
    logic [31:0] s1_pc_reg;

    // Forwarding of a write that lands at the same edge as the bank read.
    logic        fwd_src_lo_hit_reg;
    logic        fwd_src_hi_hit_reg;
    logic        fwd_dst_hit_reg;
    logic [31:0] fwd_src_lo_data_reg;
    logic [31:0] fwd_src_hi_data_reg;
    logic [31:0] fwd_dst_data_reg;
    logic        fwd_src_lo_hit_next;
    logic        fwd_src_hi_hit_next;
    logic        fwd_dst_hit_next;
    logic [31:0] fwd_src_lo_data_next;
    logic [31:0] fwd_src_hi_data_next;
    logic [31:0] fwd_dst_data_next;

    // Architectural state other than the register file.
    logic [63:0] exec_mask_reg;
    logic        cond_reg;

    // Result register.
    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     out_reg;

    // Handshake.
    logic        out_free;
    logic        advance;
    logic        accept;

    // Register banks: bank 0 holds even registers, bank 1 odd registers.
    logic [6:0]                  src_p1;
    logic [1:0]                  bank_wr_en;
    logic [1:0][BANK_AW-1:0]     bank_wr_addr;
    logic [1:0][31:0]            bank_wr_data;
    logic [1:0][BANK_AW-1:0]     bank_rd_addr_a;
    logic [1:0][31:0]            bank_rd_a;
    logic [1:0][31:0]            bank_rd_b;

    // ALU interface.
    logic [31:0] src_lo;
    logic [31:0] src_hi;
    logic [31:0] dst_old;
    wr_ctrl_t    wr;
    result_t     res;
    mask_upd_t   mask_upd;

    // The instruction stage moves on whenever the result register is empty or being
    // emptied; a new item is taken whenever the instruction stage is empty or moving on.
    assign out_free   = !out_valid_reg || !result_stall;
    assign advance    = s1_valid_reg && out_free;
    assign item_stall = s1_valid_reg && !out_free;
    assign accept     = item_valid && !item_stall;

    assign s1_valid_next  = accept || (s1_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && result_stall);

    // Bank read and write steering. A pair always spans both banks, so each bank
    // sees at most one source word, one destination word and one write per cycle.
    assign src_p1 = source_index + 7'd1;

    always_comb
    begin
        for (int b = 0; b < 2; b++)
        begin
            bank_rd_addr_a[b] = (source_index[0] == 1'(b)) ? source_index[6:1] : src_p1[6:1];
            if (wr.lo_en && (wr.lo_addr[0] == 1'(b)))
            begin
                bank_wr_en[b]   = advance;
                bank_wr_addr[b] = wr.lo_addr[6:1];
                bank_wr_data[b] = wr.lo_data;
            end
            else
            begin
                bank_wr_en[b]   = advance && wr.hi_en && (wr.hi_addr[0] == 1'(b));
                bank_wr_addr[b] = wr.hi_addr[6:1];
                bank_wr_data[b] = wr.hi_data;
            end
        end
    end

    sop1_regbank u_bank_even (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (bank_wr_en[0]),
        .wr_addr   (bank_wr_addr[0]),
        .wr_data   (bank_wr_data[0]),
        .rd_en     (accept),
        .rd_addr_a (bank_rd_addr_a[0]),
        .rd_addr_b (dest_index[6:1]),
        .rd_data_a (bank_rd_a[0]),
        .rd_data_b (bank_rd_b[0])
    );

    sop1_regbank u_bank_odd (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (bank_wr_en[1]),
        .wr_addr   (bank_wr_addr[1]),
        .wr_data   (bank_wr_data[1]),
        .rd_en     (accept),
        .rd_addr_a (bank_rd_addr_a[1]),
        .rd_addr_b (dest_index[6:1]),
        .rd_data_a (bank_rd_a[1]),
        .rd_data_b (bank_rd_b[1])
    );

    // Forwarding compare: the older instruction writes at the edge where the new one
    // reads the banks, so the bank data would be stale for a matching index.
    always_comb
    begin
        fwd_src_lo_hit_next  = advance &&
            ((wr.lo_en && (wr.lo_addr == source_index)) ||
             (wr.hi_en && (wr.hi_addr == source_index)));
        fwd_src_lo_data_next = (wr.lo_en && (wr.lo_addr == source_index)) ?
                               wr.lo_data : wr.hi_data;
        fwd_src_hi_hit_next  = advance &&
            ((wr.lo_en && (wr.lo_addr == src_p1)) ||
             (wr.hi_en && (wr.hi_addr == src_p1)));
        fwd_src_hi_data_next = (wr.lo_en && (wr.lo_addr == src_p1)) ?
                               wr.lo_data : wr.hi_data;
        fwd_dst_hit_next     = advance &&
            ((wr.lo_en && (wr.lo_addr == dest_index)) ||
             (wr.hi_en && (wr.hi_addr == dest_index)));
        fwd_dst_data_next    = (wr.lo_en && (wr.lo_addr == dest_index)) ?
                               wr.lo_data : wr.hi_data;
    end

    // Operand selection for the instruction in the stage.
    always_comb
    begin
        if (fwd_src_lo_hit_reg)
        begin
            src_lo = fwd_src_lo_data_reg;
        end
        else
        begin
            src_lo = s1_source_reg[0] ? bank_rd_a[1] : bank_rd_a[0];
        end

        if (fwd_src_hi_hit_reg)
        begin
            src_hi = fwd_src_hi_data_reg;
        end
        else
        begin
            src_hi = s1_source_reg[0] ? bank_rd_a[0] : bank_rd_a[1];
        end

        if (fwd_dst_hit_reg)
        begin
            dst_old = fwd_dst_data_reg;
        end
        else
        begin
            dst_old = s1_dest_reg[0] ? bank_rd_b[1] : bank_rd_b[0];
        end
    end

    sop1_alu u_alu (
        .action            (s1_action_reg),
        .dest_index        (s1_dest_reg),
        .source_index      (s1_source_reg),
        .source_is_literal (s1_literal_sel_reg),
        .literal_word      (s1_literal_reg),
        .current_pc        (s1_pc_reg),
        .src_lo            (src_lo),
        .src_hi            (src_hi),
        .dst_old           (dst_old),
        .exec_mask         (exec_mask_reg),
        .cond              (cond_reg),
        .wr                (wr),
        .res               (res),
        .mask_upd          (mask_upd)
    );

    // Control state, forwarding flags and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            fwd_src_lo_hit_reg <= 1'b0;
            fwd_src_hi_hit_reg <= 1'b0;
            fwd_dst_hit_reg    <= 1'b0;
            exec_mask_reg      <= '1;
            cond_reg           <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                fwd_src_lo_hit_reg <= fwd_src_lo_hit_next;
                fwd_src_hi_hit_reg <= fwd_src_hi_hit_next;
                fwd_dst_hit_reg    <= fwd_dst_hit_next;
            end
            if (advance)
            begin
                cond_reg <= res.condition_out;
                if (mask_upd.we)
                begin
                    exec_mask_reg <= mask_upd.value;
                end
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_action_reg       <= action;
            s1_dest_reg         <= dest_index;
            s1_source_reg       <= source_index;
            s1_literal_sel_reg  <= source_is_literal;
            s1_literal_reg      <= literal_word;
            s1_pc_reg           <= current_pc;
            fwd_src_lo_data_reg <= fwd_src_lo_data_next;
            fwd_src_hi_data_reg <= fwd_src_hi_data_next;
            fwd_dst_data_reg    <= fwd_dst_data_next;
        end
        if (advance)
        begin
            out_reg <= res;
        end
    end

    assign result_valid  = out_valid_reg;
    assign written_low   = out_reg.written_low;
    assign written_high  = out_reg.written_high;
    assign condition_out = out_reg.condition_out;
    assign jump_taken    = out_reg.jump_taken;
    assign jump_target   = out_reg.jump_target;
    assign error_code    = out_reg.error_code;

`ifndef SYNTHESIS
    // An item is never taken into a full stage unless that stage moves on.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s1_valid_reg) |-> advance)
        else $error("instruction stage overwritten");

    // Every instruction that leaves the stage shows up as a result.
    a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid)
        else $error("result lost after stage advance");

    // The execute mask only changes when an instruction retires.
    a_mask_on_retire: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(exec_mask_reg) |-> $past(advance))
        else $error("execute mask changed without retiring instruction");

    // A faulting instruction writes nothing into the register banks.
    a_error_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (res.error_code != ERR_NONE)) |-> (bank_wr_en == 2'b00))
        else $error("register write on faulting instruction");
`endif

endmodule

`default_nettype wire

// File: rtl/sop1_regbank.sv
// One bank of the scalar register file: 64 words, one write port, two read ports.
// Read data is registered; entries never written read as zero. Uses sop1_pkg.
`default_nettype none

module sop1_regbank (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [sop1_pkg::BANK_AW-1:0] wr_addr,
    input  logic [31:0]                 wr_data,
    input  logic                        rd_en,
    input  logic [sop1_pkg::BANK_AW-1:0] rd_addr_a,
    input  logic [sop1_pkg::BANK_AW-1:0] rd_addr_b,
    output logic [31:0]                 rd_data_a,
    output logic [31:0]                 rd_data_b
);
    import sop1_pkg::*;

    logic [31:0]           mem [BANK_DEPTH];
    logic [BANK_DEPTH-1:0] valid_reg;
    logic [31:0]           rd_data_a_reg;
    logic [31:0]           rd_data_b_reg;

    // Valid bits give the all-zero reset value without a clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // The read returns the contents from before a write at the same edge.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a_reg <= valid_reg[rd_addr_a] ? mem[rd_addr_a] : 32'd0;
            rd_data_b_reg <= valid_reg[rd_addr_b] ? mem[rd_addr_b] : 32'd0;
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

`default_nettype wire

// File: rtl/sop1_alu.sv
// Combinational execute logic for one scalar one-source instruction.
// Produces the result, the register write request and the mask update. Uses sop1_pkg.
`default_nettype none

module sop1_alu (
    input  logic [3:0]          action,
    input  logic [6:0]          dest_index,
    input  logic [6:0]          source_index,
    input  logic                source_is_literal,
    input  logic [31:0]         literal_word,
    input  logic [31:0]         current_pc,
    input  logic [31:0]         src_lo,
    input  logic [31:0]         src_hi,
    input  logic [31:0]         dst_old,
    input  logic [63:0]         exec_mask,
    input  logic                cond,
    output sop1_pkg::wr_ctrl_t  wr,
    output sop1_pkg::result_t   res,
    output sop1_pkg::mask_upd_t mask_upd
);
    import sop1_pkg::*;

    function automatic logic reg_ok(input logic [7:0] idx);
        return idx < 8'(NUM_SCALAR_REGS);
    endfunction

    logic        src64;
    logic        dst64;
    logic        need_src;
    logic        need_dst;
    logic        unsupported;
    logic        is_jump;
    logic        src_bad;
    logic        dst_bad;
    logic [7:0]  src_p1;
    logic [7:0]  dst_p1;
    logic [63:0] s;
    logic [31:0] brev;
    logic [63:0] new_mask;
    logic [1:0]  err;
    logic [31:0] wl;
    logic [31:0] wh;
    logic        jump;
    logic [31:0] tgt;
    logic        cond_n;
    logic        mask_we;

    always_comb
    begin
        src64       = 1'b0;
        dst64       = 1'b0;
        need_src    = 1'b1;
        need_dst    = 1'b1;
        unsupported = 1'b0;
        case (action)
            ACT_MOV32, ACT_NOT, ACT_BREV, ACT_BITCLR:
            begin
                src64 = 1'b0;
            end
            ACT_MOV64, ACT_ANDSAVE, ACT_ORSAVE, ACT_SWAPPC:
            begin
                src64 = 1'b1;
                dst64 = 1'b1;
            end
            ACT_GETPC:
            begin
                need_src = 1'b0;
                dst64    = 1'b1;
            end
            ACT_SETPC:
            begin
                src64    = 1'b1;
                need_dst = 1'b0;
            end
            default:
            begin
                unsupported = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        src_p1 = {1'b0, source_index} + 8'd1;
        dst_p1 = {1'b0, dest_index} + 8'd1;

        // A literal feeding a 64-bit source is sign-extended.
        if (source_is_literal)
        begin
            s = src64 ? {{32{literal_word[31]}}, literal_word} : {32'd0, literal_word};
        end
        else
        begin
            s = {(src64 ? src_hi : 32'd0), src_lo};
        end

        src_bad = need_src && !source_is_literal &&
                  (!reg_ok({1'b0, source_index}) || (src64 && !reg_ok(src_p1)));
        dst_bad = need_dst &&
                  (!reg_ok({1'b0, dest_index}) || (dst64 && !reg_ok(dst_p1)));
        is_jump = (action == ACT_SETPC) || (action == ACT_SWAPPC);

        if (unsupported)
        begin
            err = ERR_UNSUPPORTED;
        end
        else if (src_bad || dst_bad)
        begin
            err = ERR_RANGE;
        end
        else if (is_jump && (s[63:32] != 32'd0))
        begin
            err = ERR_TARGET;
        end
        else
        begin
            err = ERR_NONE;
        end

        for (int i = 0; i < 32; i++)
        begin
            brev[i] = s[31 - i];
        end

        new_mask = (action == ACT_ANDSAVE) ? (s & exec_mask) : (s | exec_mask);

        wl      = 32'd0;
        wh      = 32'd0;
        jump    = 1'b0;
        tgt     = 32'd0;
        cond_n  = cond;
        mask_we = 1'b0;
        case (action)
            ACT_MOV32:
            begin
                wl = s[31:0];
            end
            ACT_MOV64:
            begin
                wl = s[31:0];
                wh = s[63:32];
            end
            ACT_NOT:
            begin
                wl     = ~s[31:0];
                cond_n = (~s[31:0] != 32'd0);
            end
            ACT_BREV:
            begin
                wl = brev;
            end
            ACT_BITCLR:
            begin
                wl = dst_old & ~(32'd1 << s[4:0]);
            end
            ACT_GETPC:
            begin
                wl = current_pc + PC_STEP;
            end
            ACT_SETPC:
            begin
                jump = 1'b1;
                tgt  = s[31:0];
            end
            ACT_SWAPPC:
            begin
                wl   = current_pc + PC_STEP;
                jump = 1'b1;
                tgt  = s[31:0];
            end
            ACT_ANDSAVE, ACT_ORSAVE:
            begin
                wl      = exec_mask[31:0];
                wh      = exec_mask[63:32];
                mask_we = 1'b1;
                cond_n  = (new_mask != 64'd0);
            end
            default:
            begin
                wl = 32'd0;
            end
        endcase

        // Any error leaves all state untouched and clears the payload.
        if (err != ERR_NONE)
        begin
            wl      = 32'd0;
            wh      = 32'd0;
            jump    = 1'b0;
            tgt     = 32'd0;
            cond_n  = cond;
            mask_we = 1'b0;
        end
    end

    assign wr.lo_en   = (err == ERR_NONE) && need_dst;
    assign wr.hi_en   = (err == ERR_NONE) && need_dst && dst64;
    assign wr.lo_addr = dest_index;
    assign wr.hi_addr = dst_p1[6:0];
    assign wr.lo_data = wl;
    assign wr.hi_data = wh;

    assign res.written_low   = wl;
    assign res.written_high  = wh;
    assign res.condition_out = cond_n;
    assign res.jump_taken    = jump;
    assign res.jump_target   = tgt;
    assign res.error_code    = err;

    assign mask_upd.we    = mask_we;
    assign mask_upd.value = new_mask;

endmodule

`default_nettype wire
